@@ design/kmrhc_pkg.sv @@
package kmrhc_pkg;

	localparam logic [31:0] Mix32M1   = 32'h85ebca6b;
	localparam logic [31:0] Mix32M2   = 32'hc2b2ae35;
	localparam logic [63:0] Mix64M1   = 64'hff51afd7ed558ccd;
	localparam logic [63:0] Mix64M2   = 64'hc4ceb9fe1a85ec53;
	localparam logic [63:0] CombineK  = 64'h000000009e3779b9;

	localparam int QueueDepth = 2;

	localparam logic OP_KEY32 = 1'b0;
	localparam logic OP_KEY64 = 1'b1;

	localparam logic [1:0] XS_PRE = 2'd0;
	localparam logic [1:0] XS_MID = 2'd1;
	localparam logic [1:0] XS_END = 2'd2;

	typedef struct packed {
		logic signed [63:0] key;
		logic               opcode;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic [63:0] element_hash;
		logic [63:0] record_hash;
		logic        final_res;
	} out_item_t;

	typedef struct packed {
		logic [63:0] hash;
		logic        last;
	} mix_item_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL_LO,
		F_MUL_HI,
		F_MUL_X,
		F_SHIFT,
		F_PUSH
	} front_state_t;

	function automatic logic [63:0] xorshift(input logic [63:0] h, input logic op,
		input logic [1:0] step);
		logic [63:0] r;
		r = h;
		if (op == OP_KEY64) begin
			r = h ^ (h >> 33);
		end else begin
			case (step)
				XS_PRE:  r = h ^ (h >> 16);
				XS_MID:  r = h ^ (h >> 13);
				XS_END:  r = h ^ (h >> 16);
				default: r = h;
			endcase
		end
		return r;
	endfunction

endpackage

@@ design/key_mix_and_record_hash_combine_core.sv @@
// A transaction passes the mixer, the queue and the output register before the result ports.
// The mixer sequencer takes no new transaction until it has pushed the last one; it runs
// both 64-bit multiplies through one shared 32x32 multiplier in three partial products each.
// Combine stage and output register take one transaction per cycle unless a result is held.
// Reset clears the running seed, the mixer state, the queue and the output valid flag.
// There is no clearing pass.
module key_mix_and_record_hash_combine_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  kmrhc_pkg::in_item_t   item,
	output logic                  empty,
	input  logic                  pop,
	output kmrhc_pkg::out_item_t  result
);
	import kmrhc_pkg::*;

	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_empty;
	mix_item_t q_wr_data;
	mix_item_t q_rd_data;

	kmrhc_mixer u_mixer (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_push (q_push),
		.q_full (q_full),
		.q_data (q_wr_data)
	);

	kmrhc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.full    (q_full),
		.wr_data (q_wr_data),
		.rd_en   (q_pop),
		.empty   (q_empty),
		.rd_data (q_rd_data)
	);

	kmrhc_combine u_combine (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rd_data),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("Internal queue reports full and empty at once.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> full)
		else $error("Mixer accepted a transaction but did not go busy.");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && q_empty) |=> empty)
		else $error("Result remained after the last transaction was taken.");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && q_empty) |=> empty)
		else $error("Result appeared with no transaction in the queue.");

endmodule

@@ design/kmrhc_mixer.sv @@
module kmrhc_mixer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  kmrhc_pkg::in_item_t   item,
	output logic                  q_push,
	input  logic                  q_full,
	output kmrhc_pkg::mix_item_t  q_data
);
	import kmrhc_pkg::*;

	front_state_t state_q, state_next;
	logic [63:0] h_q;
	logic [63:0] acc_q;
	logic        op_q;
	logic        last_q;
	logic        round_q;
	logic [31:0] a_sel;
	logic [31:0] m_lo;
	logic [31:0] m_hi;
	logic [31:0] m_sel;
	logic [63:0] product;
	logic [63:0] key_ext;

	always_comb begin
		if (round_q == 1'b0) begin
			m_lo = (op_q == OP_KEY64) ? Mix64M1[31:0] : Mix32M1;
			m_hi = (op_q == OP_KEY64) ? Mix64M1[63:32] : 32'd0;
		end else begin
			m_lo = (op_q == OP_KEY64) ? Mix64M2[31:0] : Mix32M2;
			m_hi = (op_q == OP_KEY64) ? Mix64M2[63:32] : 32'd0;
		end
		a_sel = (state_q == F_MUL_HI) ? h_q[63:32] : h_q[31:0];
		m_sel = (state_q == F_MUL_X) ? m_hi : m_lo;
	end

	assign product = a_sel * m_sel;
	assign key_ext = (item.opcode == OP_KEY64) ? 64'(item.key)
		: {{32{item.key[31]}}, item.key[31:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		full       = 1'b1;
		q_push     = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				full = 1'b0;
				if (push) begin
					state_next = F_MUL_LO;
				end
			end
			F_MUL_LO: state_next = F_MUL_HI;
			F_MUL_HI: state_next = F_MUL_X;
			F_MUL_X:  state_next = F_SHIFT;
			F_SHIFT:  state_next = round_q ? F_PUSH : F_MUL_LO;
			F_PUSH: begin
				q_push = 1'b1;
				if (!q_full) begin
					state_next = F_IDLE;
				end
			end
			default: state_next = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= 1'b0;
		end else if (state_q == F_IDLE && push) begin
			round_q <= 1'b0;
		end else if (state_q == F_SHIFT) begin
			round_q <= ~round_q;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (push) begin
					h_q    <= xorshift(key_ext, item.opcode, XS_PRE);
					op_q   <= item.opcode;
					last_q <= item.last;
				end
			end
			F_MUL_LO: acc_q <= product;
			F_MUL_HI: acc_q[63:32] <= acc_q[63:32] + product[31:0];
			F_MUL_X:  acc_q[63:32] <= acc_q[63:32] + product[31:0];
			F_SHIFT:  h_q <= xorshift(acc_q, op_q, round_q ? XS_END : XS_MID);
			default: ;
		endcase
	end

	assign q_data.hash = h_q;
	assign q_data.last = last_q;

endmodule

@@ design/kmrhc_queue.sv @@
module kmrhc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	output logic                  full,
	input  kmrhc_pkg::mix_item_t  wr_data,
	input  logic                  rd_en,
	output logic                  empty,
	output kmrhc_pkg::mix_item_t  rd_data
);
	import kmrhc_pkg::*;

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
	localparam logic [CntW-1:0] DepthCnt = CntW'(QueueDepth);

	mix_item_t       mem_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (count_q == DepthCnt);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ design/kmrhc_combine.sv @@
module kmrhc_combine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  kmrhc_pkg::mix_item_t  q_data,
	output logic                  q_pop,
	output logic                  empty,
	input  logic                  pop,
	output kmrhc_pkg::out_item_t  result
);
	import kmrhc_pkg::*;

	logic [63:0] seed_q;
	logic        valid_q;
	out_item_t   out_q;
	logic [63:0] sum;
	logic [63:0] rec;

	assign q_pop = !q_empty && (!valid_q || pop);
	assign sum   = q_data.hash + CombineK + (seed_q << 6) + (seed_q >> 2);
	assign rec   = sum ^ seed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= '0;
			valid_q <= 1'b0;
		end else if (q_pop) begin
			seed_q  <= q_data.last ? '0 : rec;
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q.element_hash <= q_data.hash;
			out_q.record_hash  <= rec;
			out_q.final_res    <= q_data.last;
		end
	end

	assign empty  = !valid_q;
	assign result = out_q;

endmodule
